// ----- hw/rtl/crc_sw_pkg.sv -----
// Package for the selectable-width CRC core: sizes, register indexes,
// width select codes and the degree/mask helpers.
// No dependencies.
package crc_sw_pkg;

  // Largest CRC degree the core supports.
  localparam int MAX_WIDTH = 64;

  // Field widths.
  localparam int DATA_W  = 8;
  localparam int CRC_W   = 64;
  localparam int WSEL_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  // Degree value needs to hold MAX_WIDTH itself, bit index needs MAX_WIDTH-1.
  localparam int DEG_W = $clog2(MAX_WIDTH + 1);
  localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_TAPS    = 1'd1;

  // Width select codes.
  localparam logic [WSEL_W-1:0] WSEL_8  = 3'd0;
  localparam logic [WSEL_W-1:0] WSEL_16 = 3'd1;
  localparam logic [WSEL_W-1:0] WSEL_24 = 3'd2;
  localparam logic [WSEL_W-1:0] WSEL_32 = 3'd3;
  localparam logic [WSEL_W-1:0] WSEL_64 = 3'd4;

  // Reset values of the registers.
  localparam logic [WSEL_W-1:0] WSEL_RESET = WSEL_32;
  localparam logic [CRC_W-1:0]  POLY_RESET = 64'h0000_0000_04C1_1DB7;

  // Per-byte control derived from the registers.
  typedef struct packed {
    logic [CRC_W-1:0] mask;     // ones below the degree
    logic [CRC_W-1:0] taps;     // polynomial terms, masked to the degree
    logic [IDX_W-1:0] top_idx;  // degree - 1
  } crc_ctrl_t;

  // Degree for a width select code; codes above four mean 64.
  function automatic logic [DEG_W-1:0] sel_to_degree(input logic [WSEL_W-1:0] sel);
    logic [7:0] raw;
    case (sel)
      WSEL_8:  raw = 8'd8;
      WSEL_16: raw = 8'd16;
      WSEL_24: raw = 8'd24;
      WSEL_32: raw = 8'd32;
      default: raw = 8'd64;
    endcase
    if (raw > 8'(MAX_WIDTH)) begin
      raw = 8'(MAX_WIDTH);
    end
    return DEG_W'(raw);
  endfunction

  // Mask of ones below the degree (a shift by the full width gives zero).
  function automatic logic [CRC_W-1:0] degree_mask(input logic [DEG_W-1:0] deg);
    return ~({CRC_W{1'b1}} << deg);
  endfunction

endpackage

// ----- hw/rtl/crc_sw_if.sv -----
// Channel interfaces for the selectable-width CRC core: message bytes,
// CRC results and configuration writes. Depends on crc_sw_pkg.

// Message byte channel.
interface crc_sw_msg_if;
  import crc_sw_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// CRC result channel.
interface crc_sw_res_if;
  import crc_sw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CRC_W-1:0] crc_value;
  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

// Configuration write channel.
interface crc_sw_cfg_if;
  import crc_sw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/crc_selectable_width_core.sv -----
// Top level of the selectable-width CRC core: input register, running
// remainder, result register and configuration registers.
// Depends on crc_sw_pkg, crc_sw_if and crc_sw_step.
//
//  channel | modport | payload                  | transaction
//  --------+---------+--------------------------+------------------------------
//  msg     | sink    | data_byte[7:0], last_byte | one message byte
//  result  | source  | crc_value[63:0]           | one CRC, after a last byte
//  cfg     | sink    | index[0], data[63:0]      | one register write
//
// A byte is taken every cycle unless a last byte waits for a stalled result;
// it is held in the input register and then folded into the remainder, and a
// last byte's CRC is loaded into the result register at that same edge, raising
// result.valid. The byte path is one 8-step XOR network on the 64-bit remainder.
// Reset (synchronous) clears the remainder and restores width 32 and the
// CRC-32 taps. A stalled result holds only a last byte in the input
// register; other bytes keep flowing. cfg is always ready.
module crc_selectable_width_core (
  input  logic         clk,
  input  logic         rst,
  crc_sw_msg_if.sink   msg,
  crc_sw_res_if.source result,
  crc_sw_cfg_if.sink   cfg
);
  import crc_sw_pkg::*;

  logic [WSEL_W-1:0] width_select;
  logic [CRC_W-1:0]  poly_taps;
  logic [CRC_W-1:0]  remainder;

  logic              s1_valid;
  logic [DATA_W-1:0] s1_byte;
  logic              s1_last;
  logic              s1_fire;

  logic              res_valid;
  logic [CRC_W-1:0]  res_value;

  crc_ctrl_t         ctrl;
  logic [DEG_W-1:0]  deg;
  logic [CRC_W-1:0]  rem_next;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_select <= WSEL_RESET;
      poly_taps    <= POLY_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WIDTH_SELECT: width_select <= cfg.data[WSEL_W-1:0];
        REG_POLY_TAPS:    poly_taps    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Control derived from the registers
  always_comb begin
    deg          = sel_to_degree(width_select);
    ctrl.mask    = degree_mask(deg);
    ctrl.taps    = poly_taps & ctrl.mask;
    ctrl.top_idx = IDX_W'(deg - DEG_W'(1));
  end

  // A last byte advances only when the result register is free
  assign s1_fire   = s1_valid && (!s1_last || !res_valid || result.ready);
  assign msg.ready = !s1_valid || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
    if (msg.ready && msg.valid) begin
      s1_byte <= msg.data_byte;
      s1_last <= msg.last_byte;
    end
  end

  crc_sw_step u_step (
    .ctrl      (ctrl),
    .rem_in    (remainder),
    .data_byte (s1_byte),
    .rem_out   (rem_next)
  );

  // Running remainder, cleared after a last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (s1_fire) begin
      remainder <= s1_last ? '0 : rem_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      res_value <= rem_next;
    end
  end

  assign result.valid     = res_valid;
  assign result.crc_value = res_value;

  // Checks
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> res_valid)
    else $error("last byte did not produce a result");

  a_last_clears_rem: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> remainder == '0)
    else $error("remainder not cleared after last byte");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> msg.ready)
    else $error("input not ready with empty input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready && s1_valid && s1_last |-> !s1_fire)
    else $error("pending result would be overwritten");

endmodule

// ----- hw/rtl/crc_sw_step.sv -----
// Byte-wide CRC update: eight MSB-first shift/XOR steps on the remainder.
// Depends on crc_sw_pkg.
module crc_sw_step (
  input  crc_sw_pkg::crc_ctrl_t          ctrl,
  input  logic [crc_sw_pkg::CRC_W-1:0]   rem_in,
  input  logic [crc_sw_pkg::DATA_W-1:0]  data_byte,
  output logic [crc_sw_pkg::CRC_W-1:0]   rem_out
);
  import crc_sw_pkg::*;

  // One step per message bit, most significant first
  always_comb begin
    logic [CRC_W-1:0] rem;
    logic             top;
    rem = rem_in & ctrl.mask;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      top = rem[ctrl.top_idx] ^ data_byte[i];
      rem = (rem << 1) & ctrl.mask;
      if (top) begin
        rem = rem ^ ctrl.taps;
      end
    end
    rem_out = rem;
  end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for crc_selectable_width_core: drives message bytes
// and register writes, predicts every CRC and checks each result transaction.
// Depends on crc_sw_pkg, crc_sw_if and crc_selectable_width_core.
module testbench;
  import crc_sw_pkg::*;

  // Cycles to let a folded byte settle before touching the registers.
  localparam int SETTLE_CYCLES = 6;
  // Hard stop for a hung run, in time units.
  localparam int RUN_LIMIT = 2_000_000;
  // Most mismatches printed in full.
  localparam int REPORT_MAX = 10;

  // Width select code above the defined range; the core treats it as 64.
  localparam logic [WSEL_W-1:0] WSEL_TOP_CODE = 3'd7;

  // Well-known generator taps (top term implicit).
  localparam logic [CRC_W-1:0] TAPS_CRC8  = 64'h0000_0000_0000_00D5;
  localparam logic [CRC_W-1:0] TAPS_CRC16 = 64'h0000_0000_0000_1021;
  localparam logic [CRC_W-1:0] TAPS_CRC24 = 64'h0000_0000_0080_0063;
  localparam logic [CRC_W-1:0] TAPS_CRC64 = 64'h0000_0000_0000_001B;

  typedef enum int unsigned {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG_STALL} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crc_sw_msg_if msg_if ();
  crc_sw_res_if res_if ();
  crc_sw_cfg_if cfg_if ();

  crc_selectable_width_core dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  // Shadow copy of the core's registers and running remainder
  logic [WSEL_W-1:0] shadow_wsel = WSEL_RESET;
  logic [CRC_W-1:0]  shadow_taps = POLY_RESET;
  logic [CRC_W-1:0]  running_rem = '0;
  logic [CRC_W-1:0]  pending_crcs[$];
  int unsigned       fail_count = 0;

  // Sender burst state
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  // Receiver stall pattern state
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_tick = 0;

  // CRC degree for a width select code; anything above four means 64
  function automatic int unsigned degree_of_code(input logic [WSEL_W-1:0] code);
    case (code)
      WSEL_8:  return 8;
      WSEL_16: return 16;
      WSEL_24: return 24;
      WSEL_32: return 32;
      default: return 64;
    endcase
  endfunction

  // Fold one byte, MSB first, into the remainder at the given degree
  function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] rem,
                                                     input logic [DATA_W-1:0] data,
                                                     input logic [WSEL_W-1:0] code,
                                                     input logic [CRC_W-1:0] taps);
    int unsigned      deg;
    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] t;
    logic [CRC_W-1:0] r;
    logic             top;
    deg  = degree_of_code(code);
    mask = (deg >= 64) ? {CRC_W{1'b1}} : ((64'd1 << deg) - 64'd1);
    t    = taps & mask;
    r    = rem & mask;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      top = r[deg-1] ^ data[i];
      r   = (r << 1) & mask;
      if (top) begin
        r = r ^ t;
      end
    end
    return r;
  endfunction

  // Random taps: well-known generators, extremes, or anything at all
  function automatic logic [CRC_W-1:0] pick_taps();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {CRC_W{1'b1}};
      2:       return TAPS_CRC8;
      3:       return TAPS_CRC16;
      4:       return TAPS_CRC24;
      5:       return POLY_RESET;
      6:       return TAPS_CRC64;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Monitor: tracks register writes and bytes, checks result transactions
  always @(posedge clk) begin : monitor
    logic [CRC_W-1:0] want;
    logic [CRC_W-1:0] next_rem;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_crcs.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("%0t: unexpected crc %h", $realtime, res_if.crc_value);
          end
        end else begin
          want = pending_crcs.pop_front();
          if (res_if.crc_value !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("%0t: crc mismatch, expected %h got %h",
                       $realtime, want, res_if.crc_value);
            end
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_WIDTH_SELECT: shadow_wsel = cfg_if.data[WSEL_W-1:0];
          REG_POLY_TAPS:    shadow_taps = cfg_if.data;
          default:          ;
        endcase
      end
      if (msg_if.valid && msg_if.ready) begin
        next_rem = crc_fold_byte(running_rem, msg_if.data_byte, shadow_wsel, shadow_taps);
        if (msg_if.last_byte) begin
          pending_crcs.push_back(next_rem);
          running_rem = '0;
        end else begin
          running_rem = next_rem;
        end
      end
    end
  end

  // Receiver: ready follows a pattern picked at random from the rx_mode_e modes
  always @(negedge clk) begin
    if (rx_tick % 48 == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
    end
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS:   res_if.ready = 1'b1;
      RX_RANDOM:   res_if.ready = 1'($urandom_range(0, 1));
      RX_PERIODIC: res_if.ready = (rx_tick % 4) != 0;
      default:     res_if.ready = (rx_tick % 9) < 3;
    endcase
  end

  // Send one message byte; gaps fall between bursts of random length
  task automatic send_byte(input logic [DATA_W-1:0] data, input logic last);
    int unsigned gap;
    gap = 0;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    if (gap > 0) begin
      msg_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_if.valid     = 1'b1;
    msg_if.data_byte = data;
    msg_if.last_byte = last;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected CRC has come out
  task automatic wait_drained();
    @(negedge clk);
    msg_if.valid = 1'b0;
    while (pending_crcs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write, only once the core is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Defaults after reset: CRC-32 taps over the ASCII check string, then zeros
  task automatic test_reset_defaults();
    for (int i = 1; i <= 9; i++) begin
      send_byte(8'h30 + 8'(i), i == 9);
    end
    for (int i = 0; i < 4; i++) begin
      send_byte(8'h00, i == 3);
    end
  endtask

  // Width codes 8, 16, 24 and 64, and one code above the defined range
  task automatic test_width_codes();
    logic [WSEL_W-1:0] codes[5];
    codes = '{WSEL_8, WSEL_16, WSEL_24, WSEL_64, WSEL_TOP_CODE};
    foreach (codes[i]) begin
      write_reg(REG_WIDTH_SELECT, CFG_DATA_W'(codes[i]));
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
    end
  endtask

  // Tap extremes: no terms at all, and every bit set (bits above degree ignored), at width 64 and at width 8
  task automatic test_tap_extremes();
    write_reg(REG_POLY_TAPS, '0);
    send_byte(8'hA5, 1'b1);
    write_reg(REG_POLY_TAPS, {CFG_DATA_W{1'b1}});
    send_byte(8'h01, 1'b1);
    write_reg(REG_WIDTH_SELECT, CFG_DATA_W'(WSEL_8));
    send_byte(8'hFF, 1'b1);
  endtask

  // Width switched between bytes of one message
  task automatic test_width_change_mid_message();
    write_reg(REG_POLY_TAPS, POLY_RESET);
    write_reg(REG_WIDTH_SELECT, CFG_DATA_W'(WSEL_32));
    send_byte(8'hC3, 1'b0);
    send_byte(8'h5A, 1'b0);
    write_reg(REG_WIDTH_SELECT, CFG_DATA_W'(WSEL_8));
    send_byte(8'h7E, 1'b1);
  endtask

  // Random messages over several register settings
  task automatic test_random_traffic();
    int unsigned       phase_sent;
    int unsigned       len;
    int unsigned       split;
    bit                zeros;
    logic [WSEL_W-1:0] code;
    for (int phase = 0; phase < 10; phase++) begin
      gaps_on = (phase % 3) != 2;
      if (phase == 0) begin
        code = WSEL_8;
      end else if (phase == 1) begin
        code = WSEL_64;
      end else begin
        code = WSEL_W'($urandom_range(0, 7));
      end
      write_reg(REG_WIDTH_SELECT, CFG_DATA_W'(code));
      write_reg(REG_POLY_TAPS, pick_taps());
      phase_sent = 0;
      while (phase_sent < 80) begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        zeros = ($urandom_range(0, 15) == 0);
        split = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
        for (int i = 0; i < len; i++) begin
          // occasional register change in the middle of a message
          if (split != 0 && i == split) begin
            write_reg(REG_WIDTH_SELECT, CFG_DATA_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 1) == 1) begin
              write_reg(REG_POLY_TAPS, pick_taps());
            end
          end
          send_byte(zeros ? 8'h00 : 8'($urandom), i == len - 1);
        end
        phase_sent += len;
        // now and then, hold off until all results are out
        if ($urandom_range(0, 19) == 0) begin
          wait_drained();
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Main sequence
  initial begin
    msg_if.valid     = 1'b0;
    msg_if.data_byte = '0;
    msg_if.last_byte = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_WIDTH_SELECT;
    cfg_if.data      = '0;
    res_if.ready     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_width_codes();
    test_tap_extremes();
    test_width_change_mid_message();
    test_random_traffic();

    wait_drained();
    if (fail_count == 0 && pending_crcs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
